@@ sv/slid_pkg.sv @@
// Package for the sorted list insert/delete unit: sizes, value and op types,
// and the link structs passed between neighboring storage cells.
// No dependencies.
`default_nettype none

package slid_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  // Stream widths, padded to whole bytes
  localparam int IN_DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((VALUE_BITS + COUNT_BITS + 7) / 8) * 8;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0]        count_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  // Handed rightward: what the left neighbor holds and how it compares
  typedef struct packed {
    logic   valid;
    logic   here;   // neighbor is empty or holds a value not below the key
    logic   hit;    // a match was found at or left of the neighbor
    value_t value;
  } fwd_link_t;

  // Handed leftward: the right neighbor's contents for a delete shift
  typedef struct packed {
    logic   valid;
    value_t value;
  } bwd_link_t;

  // Per-beat commands broadcast to every cell
  typedef struct packed {
    logic   ins_en;
    logic   del_en;
    value_t key;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ sv/slid_cell.sv @@
// One storage cell of the sorted row: holds a value and its valid bit,
// compares against the broadcast key and shifts with its neighbors.
// Depends on slid_pkg.
`default_nettype none

module slid_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  slid_pkg::cell_cmd_t  cmd,
  input  slid_pkg::fwd_link_t  from_left,
  input  slid_pkg::bwd_link_t  from_right,
  output slid_pkg::fwd_link_t  to_right,
  output slid_pkg::bwd_link_t  to_left
);
  import slid_pkg::*;

  value_t entry;
  logic   valid;
  logic   here;
  logic   match;
  logic   hit;

  // Empty cells count as "not smaller" so an insert lands at the tail
  assign here  = !valid || (entry >= cmd.key);
  assign match = valid && (entry == cmd.key);
  assign hit   = from_left.hit || match;

  assign to_right = '{valid: valid, here: here, hit: hit, value: entry};
  assign to_left  = '{valid: valid, value: entry};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ins_en && here) begin
      valid <= valid || from_left.valid;
    end else if (cmd.del_en && hit) begin
      valid <= from_right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_en && here) begin
      entry <= from_left.here ? from_left.value : cmd.key;
    end else if (cmd.del_en && hit) begin
      entry <= from_right.value;
    end
  end

endmodule

`default_nettype wire

@@ sv/sorted_list_insert_delete_unit.sv @@
// Sorted list insert/delete unit: a ascending row of compare-and-shift cells
// with a registered result stage. Depends on slid_pkg and slid_cell.
//
// The unit keeps up to CAPACITY signed values in ascending order in a row of
// cells, cell 0 holding the smallest. Each input beat carries an op in tuser
// (0 insert, 1 delete) and a value in tdata. An insert goes in front of the
// first entry that is not smaller, so duplicates are kept; into a full list
// it is refused with ok low. A delete removes the first entry equal to the
// value, returning it in removed_value with ok high, or ok low and zero when
// absent. Every beat yields exactly one result beat, which also reports the
// entry count after the operation. Every cell compares against the
// broadcast value and shifts with its neighbor in the same edge, and the
// result appears in the output register on the next cycle, so a new beat
// is taken each cycle while the output is free or being drained. The
// longest path is the delete match chain rippling through all CAPACITY
// cells.
`default_nettype none

module sorted_list_insert_delete_unit (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [slid_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,  // [31:0] value
  input  wire                                 s_axis_tuser,  // [0] op
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [slid_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,  // [31:0] removed_value,
                                                             // [36:32] entry_count
  output logic                                m_axis_tuser   // [0] ok
);
  import slid_pkg::*;

  fwd_link_t fwd [CAPACITY+1];
  bwd_link_t bwd [CAPACITY+1];
  cell_cmd_t cmd;

  logic                accept;
  op_t                 op;
  value_t              key;
  logic                full;
  logic                found;
  logic [CAPACITY-1:0] valid_vec;

  count_t stored_count;
  count_t count_next;
  logic   ok_next;
  value_t removed_next;

  // Output register
  logic   out_valid;
  logic   ok;
  value_t removed_value;
  count_t entry_count;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = op_t'(s_axis_tuser);
  assign key           = s_axis_tdata[VALUE_BITS-1:0];
  assign full          = (stored_count == count_t'(CAPACITY));

  // Left edge: an always-valid boundary that is smaller than any key
  assign fwd[0]        = '{valid: 1'b1, here: 1'b0, hit: 1'b0, value: '0};
  // Right edge: empty, so the tail cell drains on a delete shift
  assign bwd[CAPACITY] = '{valid: 1'b0, value: '0};

  assign cmd.key    = key;
  assign cmd.ins_en = accept && (op == OP_INSERT) && !full;
  assign cmd.del_en = accept && (op == OP_DELETE);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slid_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .from_left (fwd[i]),
      .from_right(bwd[i+1]),
      .to_right  (fwd[i+1]),
      .to_left   (bwd[i])
    );
    assign valid_vec[i] = bwd[i].valid;
  end

  // The match chain leaves the last cell high when any entry matched
  assign found = fwd[CAPACITY].hit;

  always_comb begin
    count_next   = stored_count;
    ok_next      = 1'b0;
    removed_next = '0;
    unique case (op)
      OP_INSERT: begin
        if (!full) begin
          count_next = stored_count + count_t'(1);
          ok_next    = 1'b1;
        end
      end
      OP_DELETE: begin
        // A match means the removed entry equals the key itself
        if (found) begin
          count_next   = stored_count - count_t'(1);
          ok_next      = 1'b1;
          removed_next = key;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        stored_count <= count_next;
        out_valid    <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      ok            <= ok_next;
      removed_value <= removed_next;
      entry_count   <= count_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = ok;
  assign m_axis_tdata  = OUT_DATA_BITS'({entry_count, removed_value});

  // Count register agrees with the number of occupied cells
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(stored_count))
    else $error("stored count disagrees with occupied cells");

  // Occupied cells form a contiguous run from cell 0
  a_valid_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("occupied cells are not packed at the low end");

  // An accepted beat always produces a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted beat gave no result");

  // A refused or missed operation reports a zero removed value
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !ok) |-> (removed_value == '0))
    else $error("nonzero removed value without ok");

  // A refused insert leaves the list full
  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_INSERT) && full) |=> (entry_count == count_t'(CAPACITY)))
    else $error("refused insert changed the count");

endmodule

`default_nettype wire

@@ bench/tb_sorted_list_insert_delete_unit.sv @@
// Self-checking bench for sorted_list_insert_delete_unit: directed rows, then
// random insert/delete traffic under bursty input and a stalling output.
// Depends on slid_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_sorted_list_insert_delete_unit;
  import slid_pkg::*;

  localparam int     RANDOM_ITEMS = 450;
  localparam int     PHASE_ITEMS  = 30;   // items per insert/delete bias phase
  localparam int     HOLD_CYCLES  = 64;   // long output hold-off, fills the unit
  localparam int     HOLD_ITEMS   = 48;   // gapless items offered during it
  localparam int     IDLE_LIMIT   = 2000; // cycles with no beat on either side
  localparam value_t VMAX         = 32'sh7FFF_FFFF;
  localparam value_t VMIN         = 32'sh8000_0000;

  // One result beat: ok in tuser, removed value and entry count in tdata
  typedef struct packed {
    logic   ok;
    value_t removed;
    count_t count;
  } list_outcome_t;

  // Directed row: fixed set means the outcome is typed in, else predicted
  typedef struct {
    op_t           op;
    value_t        value;
    bit            fixed;
    list_outcome_t want;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;   // [31:0] value
  logic                     s_axis_tuser = 1'b0; // [0] op
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;        // [31:0] removed_value, [36:32] entry_count
  logic                     m_axis_tuser;        // [0] ok

  // Shadow copy of the sorted store, ascending from entry 0
  value_t        shadow_list [CAPACITY];
  int            shadow_count = 0;
  list_outcome_t outcome_q [$];
  stim_row_t     directed_rows [$];
  int            error_count = 0;
  int            idle_cycles = 0;
  bit            hold_off_req = 1'b0;

  sorted_list_insert_delete_unit uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Apply one operation to the shadow store and return the beat it yields.
  // Insert goes before the first entry not smaller; delete takes the first
  // equal entry. Full store and absent value leave everything unchanged.
  function automatic list_outcome_t apply_list_op(op_t op, value_t v);
    list_outcome_t res;
    int            pos;
    res = '0;
    pos = shadow_count;
    if (op == OP_INSERT) begin
      if (shadow_count < CAPACITY) begin
        for (int i = 0; i < shadow_count; i++)
          if (pos == shadow_count && shadow_list[i] >= v) pos = i;
        for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[pos] = v;
        shadow_count++;
        res.ok = 1'b1;
      end
    end else begin
      for (int i = 0; i < shadow_count; i++)
        if (pos == shadow_count && shadow_list[i] == v) pos = i;
      if (pos < shadow_count) begin
        res.removed = shadow_list[pos];
        for (int i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
        shadow_count--;
        res.ok = 1'b1;
      end
    end
    res.count = count_t'(shadow_count);
    return res;
  endfunction

  // Pick a value: stored entries (hits and duplicates), a narrow band around
  // zero, the signed extremes, or any 32-bit pattern.
  function automatic value_t pick_value(op_t op);
    int sel;
    sel = $urandom_range(0, 99);
    if (shadow_count > 0 && sel < (op == OP_DELETE ? 65 : 20))
      return shadow_list[$urandom_range(0, shadow_count - 1)];
    sel = $urandom_range(0, 3);
    case (sel)
      0: return value_t'($signed($urandom_range(0, 8)) - 4);
      1: begin
        case ($urandom_range(0, 5))
          0: return VMIN;
          1: return VMIN + 1;
          2: return VMAX;
          3: return VMAX - 1;
          4: return '0;
          default: return '1;
        endcase
      end
      default: return value_t'($urandom);
    endcase
  endfunction

  // Hold one beat on the input until the unit takes it, then log its outcome
  task automatic offer_item(op_t op, value_t v, bit fixed, list_outcome_t want);
    list_outcome_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
    predicted = apply_list_op(op, v);
    outcome_q.push_back(fixed ? want : predicted);
  endtask

  // Drop valid for a gap; a zero gap keeps the burst going
  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Receiver: runs of ready with short stalls, now and then a clean stretch,
  // and once the long hold-off that backs the unit up to its input
  initial begin
    int run_len;
    int stall_len;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        run_len   = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        stall_len = (run_len == 40) ? 0 : $urandom_range(0, 4);
        m_axis_tready <= 1'b1;
        repeat (run_len) @(posedge clk);
        if (stall_len > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  // Result checker: compare each taken beat with the oldest outcome
  always @(posedge clk) begin
    list_outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (outcome_q.size() == 0) begin
        $error("result beat with no outcome pending: ok=%0b removed=%0d count=%0d",
               m_axis_tuser, $signed(m_axis_tdata[VALUE_BITS-1:0]),
               m_axis_tdata[VALUE_BITS +: COUNT_BITS]);
        error_count++;
      end else begin
        want = outcome_q.pop_front();
        if (m_axis_tuser !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[VALUE_BITS-1:0] !== want.removed) begin
          $error("removed_value: expected %0d, got %0d", want.removed,
                 $signed(m_axis_tdata[VALUE_BITS-1:0]));
          error_count++;
        end
        if (m_axis_tdata[VALUE_BITS +: COUNT_BITS] !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count,
                 m_axis_tdata[VALUE_BITS +: COUNT_BITS]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int  insert_pct;
    int  burst_left;
    op_t op;

    // Empty store: delete misses, extremes go in, then duplicates and a
    // first-match delete, a miss on a non-empty store, fill to capacity,
    // a refused insert into the full store, and a delete of the maximum.
    directed_rows.push_back('{OP_DELETE, 32'sd0,  1'b1, '{1'b0, '0, 5'd0}});
    directed_rows.push_back('{OP_INSERT, VMAX,    1'b1, '{1'b1, '0, 5'd1}});
    directed_rows.push_back('{OP_INSERT, VMIN,    1'b1, '{1'b1, '0, 5'd2}});
    directed_rows.push_back('{OP_INSERT, 32'sd0,  1'b0, '0});
    directed_rows.push_back('{OP_INSERT, -32'sd1, 1'b0, '0});
    directed_rows.push_back('{OP_INSERT, -32'sd1, 1'b0, '0});
    directed_rows.push_back('{OP_DELETE, -32'sd1, 1'b0, '0});
    directed_rows.push_back('{OP_DELETE, VMIN,    1'b0, '0});
    directed_rows.push_back('{OP_DELETE, 32'sd5,  1'b0, '0});
    directed_rows.push_back('{OP_INSERT, 32'sd100, 1'b0, '0});
    directed_rows.push_back('{OP_INSERT, -32'sd100, 1'b0, '0});
    directed_rows.push_back('{OP_INSERT, 32'sd7,  1'b0, '0});
    directed_rows.push_back('{OP_INSERT, 32'sd7,  1'b0, '0});
    directed_rows.push_back('{OP_INSERT, 32'sd7,  1'b0, '0});
    directed_rows.push_back('{OP_INSERT, 32'sh1234_5678, 1'b0, '0});
    directed_rows.push_back('{OP_INSERT, 32'shEDCB_A988, 1'b0, '0});
    directed_rows.push_back('{OP_INSERT, 32'sd1,  1'b0, '0});
    directed_rows.push_back('{OP_INSERT, 32'sd2,  1'b0, '0});
    directed_rows.push_back('{OP_INSERT, VMIN,    1'b0, '0});
    directed_rows.push_back('{OP_INSERT, VMAX,    1'b0, '0});
    directed_rows.push_back('{OP_INSERT, 32'sh5555_5555, 1'b0, '0});
    directed_rows.push_back('{OP_INSERT, 32'shAAAA_AAAA, 1'b0, '0});
    directed_rows.push_back('{OP_INSERT, 32'sd3,  1'b1, '{1'b0, '0, 5'd16}});
    directed_rows.push_back('{OP_DELETE, VMAX,    1'b1, '{1'b1, VMAX, 5'd15}});

    // Hold reset, then release it on an edge
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      offer_item(directed_rows[r].op, directed_rows[r].value,
                 directed_rows[r].fixed, directed_rows[r].want);
      pause_sender($urandom_range(0, 2));
    end

    // Random traffic in phases that lean toward filling, draining or mixing;
    // the first items go in gapless while the receiver holds off
    hold_off_req = 1'b1;
    insert_pct   = 85;
    burst_left   = HOLD_ITEMS;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n > 0 && n % PHASE_ITEMS == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
      offer_item(op, pick_value(op), 1'b0, '0);
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        burst_left = $urandom_range(1, 16);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain the outstanding outcomes, then wait for strays before the final check
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (outcome_q.size() != 0) begin
      $error("%0d outcomes never arrived", outcome_q.size());
      error_count++;
    end
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
